FILE: sv/key_event_classifier_core_defines.svh
// Assertion macros shared by the key event classifier.
`ifndef KEY_EVENT_CLASSIFIER_CORE_DEFINES_SVH
`define KEY_EVENT_CLASSIFIER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define KEC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define KEC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KEC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define KEC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: sv/kec_pkg.sv
package kec_pkg;

  localparam int KEY_COUNT_DEF       = 20;
  localparam int EVENTS_PER_POLL_DEF = 8;
  localparam int MAX_RESULTS         = 8;
  localparam int RES_CNT_W           = $clog2(MAX_RESULTS + 1);
  localparam int KEY_W               = 5;
  localparam int TIME_W              = 32;
  localparam int RAW_W               = 8;
  localparam int CODE_W              = 7;
  localparam int PRESS_BIT           = 7;
  localparam int THR_W               = 16;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd800;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_CLICK   = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_LONG    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVENT,
    ST_REL,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic  latch;
    logic  emit;
    kind_t kind;
    logic  use_scan;
    logic  write_time;
    logic  set_held;
    logic  clr_held;
    logic  set_fired;
    logic  clr_fired;
    logic  rd_en;
    logic  rd_next;
    logic  idx_inc;
    logic  clr_poll;
    logic  flush;
  } cmd_t;

  typedef struct packed {
    logic mapped;
    logic press;
    logic held_ev;
    logic fired_ev;
    logic long_hit;
    logic idx_last;
    logic can_push;
    logic out_free;
    logic pend_valid;
  } status_t;

endpackage

FILE: sv/kec_datapath.sv
module kec_datapath #(
  parameter int KEY_COUNT       = kec_pkg::KEY_COUNT_DEF,
  parameter int EVENTS_PER_POLL = kec_pkg::EVENTS_PER_POLL_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [kec_pkg::RAW_W-1:0]   raw_event,
  input  logic [kec_pkg::TIME_W-1:0]  now_ms,
  input  logic                        cfg_we,
  input  logic [kec_pkg::THR_W-1:0]   cfg_wdata,
  input  kec_pkg::cmd_t               cmd,
  output kec_pkg::status_t            status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kec_pkg::KEY_W-1:0]   key_index,
  output logic [1:0]                  event_kind,
  output logic [kec_pkg::TIME_W-1:0]  event_time,
  output logic                        last_of_run
);

  localparam int IW     = $clog2(KEY_COUNT);
  localparam int PCW    = $clog2(EVENTS_PER_POLL + 1);
  localparam int KW     = kec_pkg::KEY_W;
  localparam int CW     = kec_pkg::CODE_W;
  localparam int TW     = kec_pkg::TIME_W;
  localparam int RCW    = kec_pkg::RES_CNT_W;
  localparam logic [CW-1:0]  KEY_CODE_MAX = CW'(KEY_COUNT);
  localparam logic [PCW-1:0] POLL_CAP     = PCW'(EVENTS_PER_POLL);
  localparam logic [RCW-1:0] RES_CAP      = RCW'(kec_pkg::MAX_RESULTS);

  logic [kec_pkg::THR_W-1:0] threshold;
  logic [kec_pkg::RAW_W-1:0] raw_r;
  logic [TW-1:0]             now_r;
  logic [KEY_COUNT-1:0]      held;
  logic [KEY_COUNT-1:0]      fired;
  logic [TW-1:0]             press_mem [KEY_COUNT];
  logic [TW-1:0]             rd_data;
  logic [IW-1:0]             idx;
  logic [IW-1:0]             rd_addr;
  logic [PCW-1:0]            poll_cnt;
  logic [RCW-1:0]            res_cnt;
  logic                      pend_valid;
  logic [KW-1:0]             pend_key;
  kec_pkg::kind_t            pend_kind;

  logic [CW-1:0] code;
  logic [IW-1:0] ev_idx;
  logic [IW-1:0] flag_idx;
  logic [KW-1:0] emit_key;
  logic [TW-1:0] diff;
  logic          allowed;
  logic          do_emit;
  logic          out_free;

  assign code     = raw_r[CW-1:0];
  assign ev_idx   = IW'(code - CW'(1));
  assign flag_idx = cmd.use_scan ? idx : ev_idx;
  assign emit_key = cmd.use_scan ? KW'(idx) : KW'(code - CW'(1));
  assign diff     = now_r - rd_data;
  assign allowed  = (res_cnt < RES_CAP) && (poll_cnt < POLL_CAP);
  assign do_emit  = cmd.emit && allowed;
  assign out_free = !out_valid || out_ready;
  assign rd_addr  = cmd.rd_next ? idx + IW'(1) : idx;

  always_comb begin
    status.mapped     = (code != '0) && (code <= KEY_CODE_MAX);
    status.press      = raw_r[kec_pkg::PRESS_BIT];
    status.held_ev    = held[ev_idx];
    status.fired_ev   = fired[ev_idx];
    status.long_hit   = held[idx] && !fired[idx] && (diff > TW'(threshold));
    status.idx_last   = (idx == IW'(KEY_COUNT - 1));
    status.can_push   = !pend_valid || out_free;
    status.out_free   = out_free;
    status.pend_valid = pend_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= kec_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      raw_r <= raw_event;
      now_r <= now_ms;
    end
  end

  // Press times are only used for held keys, and a key is held only after its
  // time was written, so the array needs no clearing.
  always_ff @(posedge clk) begin
    if (cmd.write_time) begin
      press_mem[ev_idx] <= now_r;
    end
    if (cmd.rd_en) begin
      rd_data <= press_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= '0;
      fired <= '0;
    end else begin
      if (cmd.set_held) begin
        held[flag_idx] <= 1'b1;
      end else if (cmd.clr_held) begin
        held[flag_idx] <= 1'b0;
      end
      if (cmd.set_fired) begin
        fired[flag_idx] <= 1'b1;
      end else if (cmd.clr_fired) begin
        fired[flag_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.latch) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_cnt <= '0;
    end else if (cmd.clr_poll) begin
      poll_cnt <= '0;
    end else if (do_emit) begin
      poll_cnt <= poll_cnt + PCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= '0;
    end else if (cmd.latch) begin
      res_cnt <= '0;
    end else if (do_emit) begin
      res_cnt <= res_cnt + RCW'(1);
    end
  end

  // One result is held back as pending so that the final one of an item can
  // be marked when the item's work ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (do_emit) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      pend_key  <= emit_key;
      pend_kind <= cmd.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((do_emit && pend_valid) || (cmd.flush && pend_valid)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((do_emit && pend_valid) || (cmd.flush && pend_valid)) begin
      key_index   <= pend_key;
      event_kind  <= pend_kind;
      event_time  <= now_r;
      last_of_run <= cmd.flush;
    end
  end

endmodule

FILE: sv/kec_ctrl.sv
module kec_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             mode,
  output logic             in_ready,
  input  kec_pkg::status_t status,
  output kec_pkg::cmd_t    cmd
);

  kec_pkg::state_t state;
  kec_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kec_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kec_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = mode ? kec_pkg::ST_SCAN_RD : kec_pkg::ST_EVENT;
        end
      end
      kec_pkg::ST_EVENT: begin
        if (status.can_push) begin
          if (status.mapped && !status.press && status.held_ev && !status.fired_ev) begin
            state_next = kec_pkg::ST_REL;
          end else begin
            state_next = kec_pkg::ST_FLUSH;
          end
        end
      end
      kec_pkg::ST_REL: begin
        if (status.can_push) begin
          state_next = kec_pkg::ST_FLUSH;
        end
      end
      kec_pkg::ST_SCAN_RD: begin
        state_next = kec_pkg::ST_SCAN_CHK;
      end
      kec_pkg::ST_SCAN_CHK: begin
        if (status.can_push && status.idx_last) begin
          state_next = kec_pkg::ST_FLUSH;
        end
      end
      kec_pkg::ST_FLUSH: begin
        if (!status.pend_valid || status.out_free) begin
          state_next = kec_pkg::ST_IDLE;
        end
      end
      default: state_next = kec_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      kec_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      kec_pkg::ST_EVENT: begin
        if (status.can_push && status.mapped) begin
          if (status.press) begin
            cmd.emit       = 1'b1;
            cmd.kind       = kec_pkg::KIND_PRESS;
            cmd.write_time = 1'b1;
            cmd.set_held   = 1'b1;
            cmd.clr_fired  = 1'b1;
          end else if (status.held_ev) begin
            cmd.emit = 1'b1;
            if (status.fired_ev) begin
              cmd.kind     = kec_pkg::KIND_RELEASE;
              cmd.clr_held = 1'b1;
            end else begin
              cmd.kind = kec_pkg::KIND_CLICK;
            end
          end
        end
      end
      kec_pkg::ST_REL: begin
        if (status.can_push) begin
          cmd.emit     = 1'b1;
          cmd.kind     = kec_pkg::KIND_RELEASE;
          cmd.clr_held = 1'b1;
        end
      end
      kec_pkg::ST_SCAN_RD: begin
        cmd.rd_en = 1'b1;
      end
      kec_pkg::ST_SCAN_CHK: begin
        cmd.use_scan = 1'b1;
        cmd.kind     = kec_pkg::KIND_LONG;
        if (status.can_push) begin
          cmd.emit      = status.long_hit;
          cmd.set_fired = status.long_hit;
          if (status.idx_last) begin
            cmd.clr_poll = 1'b1;
          end else begin
            // Fetch the next key's press time while this one is checked.
            cmd.idx_inc = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_next = 1'b1;
          end
        end
      end
      kec_pkg::ST_FLUSH: begin
        cmd.flush = status.pend_valid && status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: sv/key_event_classifier_core.sv
// Key event item: latched on acceptance and classified; each result waits in a
// pending slot, and the last leaves marked by last_of_run in the flush state. A
// new item is taken only after the return to idle. Scan item: one key entry per
// cycle unless a push stalls, via the single read port of the press time memory.
// Reset is synchronous and active high; it clears all key flags, the poll count,
// the output channel and sets the long press threshold to 800 ms.
`include "key_event_classifier_core_defines.svh"

module key_event_classifier_core #(
  parameter int KEY_COUNT       = kec_pkg::KEY_COUNT_DEF,
  parameter int EVENTS_PER_POLL = kec_pkg::EVENTS_PER_POLL_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic [kec_pkg::RAW_W-1:0]   raw_event,
  input  logic [kec_pkg::TIME_W-1:0]  now_ms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kec_pkg::KEY_W-1:0]   key_index,
  output logic [1:0]                  event_kind,
  output logic [kec_pkg::TIME_W-1:0]  event_time,
  output logic                        last_of_run,
  input  logic                        cfg_we,
  input  logic [kec_pkg::THR_W-1:0]   cfg_wdata
);

  kec_pkg::cmd_t    cmd;
  kec_pkg::status_t status;
  logic             in_xfer;
  logic             last_out;

  kec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  kec_datapath #(
    .KEY_COUNT       (KEY_COUNT),
    .EVENTS_PER_POLL (EVENTS_PER_POLL)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .raw_event   (raw_event),
    .now_ms      (now_ms),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key_index   (key_index),
    .event_kind  (event_kind),
    .event_time  (event_time),
    .last_of_run (last_of_run)
  );

  assign in_xfer  = in_valid && in_ready;
  assign last_out = out_valid && last_of_run;

  `KEC_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_xfer, !in_ready, "input taken while busy")
  `KEC_ASSERT_SAME(a_no_leftover, clk, rst, in_xfer, !status.pend_valid, "stale pending result")
  `KEC_ASSERT_NEXT(a_flush_marks_last, clk, rst, cmd.flush, last_out, "final result not marked")

endmodule
